[rtl/core/synth_voice_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define VALLOC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voice allocator assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define VALLOC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voice allocator assertion failed");

`endif

[rtl/core/valloc_pkg.sv]
// ----------------------------------------------------------------------------
// Voice allocator package
// Transaction types, event and action codes, and the scan and command types
// shared by the voice cells and the top level.
// ----------------------------------------------------------------------------
package valloc_pkg;

  // Index and rank width covering the largest supported pool of voices.
  localparam int VIDX_W = 6;
  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [6:0]        note_t;

  // Input event kinds.
  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_ALL_OFF  = 2'd3
  } kind_e;

  // Result actions.
  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_START_FREE    = 3'd1,
    ACT_RETRIGGER     = 3'd2,
    ACT_STEAL_RELEASE = 3'd3,
    ACT_STEAL_OLDEST  = 3'd4,
    ACT_RELEASE       = 3'd5,
    ACT_RELEASE_ALL   = 3'd6
  } action_e;

  // Update operations broadcast to the cells.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_RELEASE,
    UPD_FREE,
    UPD_RELEASE_ALL
  } upd_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  // One input transaction.
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] finished_voice;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0] action;
    logic [3:0] voice;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
  } out_item_t;

  // Search packet handed from cell to cell.
  typedef struct packed {
    note_t note;
    logic  match_hit;
    vidx_t match_idx;
    vidx_t match_rank;
    logic  free_hit;
    vidx_t free_idx;
    vidx_t free_rank;
    logic  rel_hit;
    vidx_t rel_idx;
    vidx_t rel_rank;
    logic  old_hit;
    vidx_t old_idx;
    vidx_t old_rank;
  } scan_pkt_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic    shift;
    upd_op_e op;
    vidx_t   idx;
    note_t   note;
    vidx_t   old_rank;
  } cell_cmd_t;

endpackage

[rtl/core/valloc_cell.sv]
// ----------------------------------------------------------------------------
// Voice cell
// Holds the state of one voice, folds it into the passing search packet and
// applies the broadcast update command.
// ----------------------------------------------------------------------------
module valloc_cell
  import valloc_pkg::*;
#(
  parameter int CellIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  scan_pkt_t pkt_i,
  output scan_pkt_t pkt_o
);

  localparam vidx_t OwnIdx = VIDX_W'(CellIdx);

  logic      active_q, active_d;
  logic      releasing_q, releasing_d;
  note_t     note_q, note_d;
  vidx_t     rank_q, rank_d;
  scan_pkt_t pkt_q, pkt_d;
  logic      own_sel;

  assign own_sel = (cmd_i.idx == OwnIdx);

  // Fold this voice into the search packet.
  always_comb begin
    pkt_d = pkt_i;
    if (!pkt_i.match_hit && active_q && (note_q == pkt_i.note)) begin
      pkt_d.match_hit  = 1'b1;
      pkt_d.match_idx  = OwnIdx;
      pkt_d.match_rank = rank_q;
    end
    if (!pkt_i.free_hit && !active_q) begin
      pkt_d.free_hit  = 1'b1;
      pkt_d.free_idx  = OwnIdx;
      pkt_d.free_rank = rank_q;
    end
    if (releasing_q && (!pkt_i.rel_hit || (rank_q > pkt_i.rel_rank))) begin
      pkt_d.rel_hit  = 1'b1;
      pkt_d.rel_idx  = OwnIdx;
      pkt_d.rel_rank = rank_q;
    end
    if (!pkt_i.old_hit || (rank_q > pkt_i.old_rank)) begin
      pkt_d.old_hit  = 1'b1;
      pkt_d.old_idx  = OwnIdx;
      pkt_d.old_rank = rank_q;
    end
  end

  // Apply the broadcast update to the voice state.
  always_comb begin
    active_d    = active_q;
    releasing_d = releasing_q;
    note_d      = note_q;
    rank_d      = rank_q;
    unique case (cmd_i.op)
      UPD_TOUCH: begin
        if (own_sel) begin
          active_d    = 1'b1;
          releasing_d = 1'b0;
          note_d      = cmd_i.note;
          rank_d      = '0;
        end else if (rank_q < cmd_i.old_rank) begin
          rank_d = rank_q + VIDX_W'(1);
        end
      end
      UPD_RELEASE: begin
        if (own_sel) begin
          releasing_d = 1'b1;
        end
      end
      UPD_FREE: begin
        if (own_sel) begin
          active_d    = 1'b0;
          releasing_d = 1'b0;
        end
      end
      UPD_RELEASE_ALL: begin
        if (active_q) begin
          releasing_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Voice state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      releasing_q <= 1'b0;
      note_q      <= '0;
      rank_q      <= OwnIdx;
    end else begin
      active_q    <= active_d;
      releasing_q <= releasing_d;
      note_q      <= note_d;
      rank_q      <= rank_d;
    end
  end

  // Packet stage toward the next cell.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

[rtl/core/synth_voice_allocator.sv]
// ----------------------------------------------------------------------------
// Synth voice allocator
// Assigns note events to a pool of voices, stealing the oldest releasing voice first and else the oldest voice.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the in channel (in_valid_i, in_ready_o, in_data_i) and one
// result per event leaves on the out channel (out_valid_o, out_ready_i,
// out_data_o). Note-on and note-off events send a search packet down a chain
// of NUM_VOICES cells, one cell per cycle, and their result is registered
// from the apply state once the search is done. Finished and all-notes-off
// events need no search and go from acceptance straight to the apply state.
// One event is in work at a time; the next is taken in the cycle after the
// result is loaded. The length of the cell chain sets how long a note event
// stays in work.
// A finished result sits in the output register while the next event is
// accepted and searched; if the receiver still stalls when that next result
// is ready, the voice update and result wait until the register frees.
// Reset clears all voice flags and notes and sets each voice's recency rank
// to its index; the block accepts events in the first cycle after reset.
// ----------------------------------------------------------------------------
module synth_voice_allocator
  import valloc_pkg::*;
#(
  parameter int NUM_VOICES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int CNT_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  in_item_t   item_q;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;
  cell_cmd_t  cmd;
  scan_pkt_t  seed;
  scan_pkt_t  chain [NUM_VOICES+1];
  scan_pkt_t  res;
  vidx_t      fin_idx;
  logic [VIDX_W+3:0] fin_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Empty search packet for the head of the chain.
  always_comb begin
    seed      = '0;
    seed.note = item_q.note;
  end

  assign chain[0] = seed;

  // Chain of voice cells.
  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    valloc_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1])
    );
  end

  assign res     = chain[NUM_VOICES];
  assign fin_ext = {{VIDX_W{1'b0}}, item_q.finished_voice};
  assign fin_idx = fin_ext[VIDX_W-1:0];

  // Controller: next state, cell command and result.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    cmd          = '0;
    cmd.op       = UPD_NONE;
    cmd.note     = item_q.note;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if ((in_data_i.kind == KIND_NOTE_ON) || (in_data_i.kind == KIND_NOTE_OFF)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        cmd.shift = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_VOICES - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          out_d        = '0;
          out_d.action = ACT_NONE;
          unique case (item_q.kind)
            KIND_NOTE_ON: begin
              cmd.op            = UPD_TOUCH;
              out_d.out_note     = item_q.note;
              out_d.out_velocity = item_q.velocity;
              priority if (res.match_hit) begin
                cmd.idx      = res.match_idx;
                cmd.old_rank = res.match_rank;
                out_d.action = ACT_RETRIGGER;
              end else if (res.free_hit) begin
                cmd.idx      = res.free_idx;
                cmd.old_rank = res.free_rank;
                out_d.action = ACT_START_FREE;
              end else if (res.rel_hit) begin
                cmd.idx      = res.rel_idx;
                cmd.old_rank = res.rel_rank;
                out_d.action = ACT_STEAL_RELEASE;
              end else begin
                cmd.idx      = res.old_idx;
                cmd.old_rank = res.old_rank;
                out_d.action = ACT_STEAL_OLDEST;
              end
              out_d.voice = cmd.idx[3:0];
            end
            KIND_NOTE_OFF: begin
              if (res.match_hit) begin
                cmd.op       = UPD_RELEASE;
                cmd.idx      = res.match_idx;
                out_d.action = ACT_RELEASE;
                out_d.voice  = res.match_idx[3:0];
              end
            end
            KIND_FINISHED: begin
              if (32'(item_q.finished_voice) < NUM_VOICES) begin
                cmd.op  = UPD_FREE;
                cmd.idx = fin_idx;
              end
            end
            KIND_ALL_OFF: begin
              cmd.op       = UPD_RELEASE_ALL;
              out_d.action = ACT_RELEASE_ALL;
            end
            default: begin
            end
          endcase
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/valloc_chk.sv]
// ----------------------------------------------------------------------------
// Voice allocator port checker
// Watches the top-level ports of the voice allocator and flags violations.
// ----------------------------------------------------------------------------
`include "synth_voice_allocator_assert.svh"

module valloc_chk
  import valloc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result holds its payload.
  `VALLOC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The block is busy in the cycle after it accepts a transaction.
  `VALLOC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Results without a single target voice report voice zero.
  `VALLOC_ASSERT_NOW(a_voice_zero, clk_i, rst_ni, out_valid_o && ((out_data_o.action == ACT_NONE) || (out_data_o.action == ACT_RELEASE_ALL)), out_data_o.voice == 4'd0)

  // Only starts, retriggers and steals carry a note and velocity.
  `VALLOC_ASSERT_NOW(a_note_zero, clk_i, rst_ni, out_valid_o && ((out_data_o.action == ACT_NONE) || (out_data_o.action == ACT_RELEASE) || (out_data_o.action == ACT_RELEASE_ALL)), (out_data_o.out_note == 7'd0) && (out_data_o.out_velocity == 7'd0))

endmodule

bind synth_voice_allocator valloc_chk u_valloc_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
